FILE: rtl/dmwbc_pkg.sv
// dmwbc_pkg: shared widths, function codes and the result type of the
// direct-mapped write-back cache; no dependencies
package dmwbc_pkg;

   localparam int ADDR_W = 10;
   localparam int FUNC_W = 3;
   localparam int BYTE_W = 8;

   typedef logic [FUNC_W-1:0] func_type;

   localparam func_type FUNC_READ  = 3'd0;
   localparam func_type FUNC_WRITE = 3'd1;
   localparam func_type FUNC_FLUSH = 3'd2;
   localparam func_type FUNC_LOAD  = 3'd3;
   localparam func_type FUNC_PEEK  = 3'd4;

   typedef struct packed {
      logic [BYTE_W-1:0] read_byte;
      logic              hit;
      logic              victim_written_back;
   } result_type;

endpackage

FILE: rtl/dmwbc_req_if.sv
// dmwbc_req_if: request channel of the cache, valid/ready plus payload
// depends on dmwbc_pkg
interface dmwbc_req_if;
   import dmwbc_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ADDR_W-1:0] byte_address;
   logic [BYTE_W-1:0] write_byte;

   modport source (output valid, output func, output byte_address, output write_byte,
                   input ready);
   modport sink   (input valid, input func, input byte_address, input write_byte,
                   output ready);
endinterface

FILE: rtl/dmwbc_rsp_if.sv
// dmwbc_rsp_if: response channel of the cache, valid/ready plus payload
// depends on dmwbc_pkg
interface dmwbc_rsp_if;
   import dmwbc_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] read_byte;
   logic              hit;
   logic              victim_written_back;

   modport source (output valid, output read_byte, output hit, output victim_written_back,
                   input ready);
   modport sink   (input valid, input read_byte, input hit, input victim_written_back,
                   output ready);
endinterface

FILE: rtl/dmwbc_ram.sv
// dmwbc_ram: generic single-write, single-read synchronous ram with a
// registered read port; no dependencies
module dmwbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/direct_mapped_write_back_cache.sv
// a hit, a load or a peek goes through the lookup state to the response register; a miss
// also fills the line, after first writing back a dirty victim
// flush walks every set and writes back each valid line; one request in flight at a time,
// and the single read port of each ram walks a line one byte per cycle
// after reset the backing memory is cleared with ready low
// NUM_SETS, LINE_BYTES and MEM_BYTES are powers of two
module direct_mapped_write_back_cache #(
   parameter int NUM_SETS   = 8,
   parameter int LINE_BYTES = 8,
   parameter int MEM_BYTES  = 1024
) (
   input  logic        clock,
   input  logic        reset,
   dmwbc_req_if.sink   req_ch,
   dmwbc_rsp_if.source rsp_ch
);
   import dmwbc_pkg::*;

   localparam int OFF_W   = $clog2(LINE_BYTES);
   localparam int SET_W   = $clog2(NUM_SETS);
   localparam int MEM_AW  = $clog2(MEM_BYTES);
   localparam int LINE_AW = SET_W + OFF_W;
   localparam int BASE_W  = OFF_W + SET_W + 1;
   localparam int EXT0_W  = (ADDR_W > BASE_W) ? ADDR_W : BASE_W;
   localparam int EXT_W   = (EXT0_W > MEM_AW) ? EXT0_W : MEM_AW;
   localparam int TAG_W   = EXT_W - OFF_W - SET_W;

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_LOOKUP = 8'b0000_0100,
      ST_FL_TAG = 8'b0000_1000,
      ST_FL_CHK = 8'b0001_0000,
      ST_WB     = 8'b0010_0000,
      ST_FILL   = 8'b0100_0000,
      ST_HOLD   = 8'b1000_0000
   } state_type;

   // control state
   state_type          state_ff, state_in;
   logic [MEM_AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [NUM_SETS-1:0] valid_ff, valid_in;
   logic [NUM_SETS-1:0] dirty_ff, dirty_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // working registers
   func_type           func_ff, func_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [TAG_W-1:0]   vic_tag_ff, vic_tag_in;
   logic [SET_W-1:0]   cur_set_ff, cur_set_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [BYTE_W-1:0]  wbyte_ff, wbyte_in;
   logic [OFF_W:0]     cnt_ff, cnt_in;
   logic               wb_flag_ff, wb_flag_in;
   logic [BYTE_W-1:0]  cap_rd_ff, cap_rd_in;
   result_type         hold_res_ff, hold_res_in;
   result_type         rsp_res_ff, rsp_res_in;

   // ram ports
   logic               tag_we;
   logic [SET_W-1:0]   tag_waddr, tag_raddr;
   logic [TAG_W-1:0]   tag_wdata, tag_rdata;
   logic               line_we;
   logic [LINE_AW-1:0] line_waddr, line_raddr;
   logic [BYTE_W-1:0]  line_wdata, line_rdata;
   logic               mem_we;
   logic [MEM_AW-1:0]  mem_waddr, mem_raddr;
   logic [BYTE_W-1:0]  mem_wdata, mem_rdata;

   logic [EXT_W-1:0]   req_addr_ext;
   logic [TAG_W-1:0]   req_tag;
   logic [SET_W-1:0]   req_set;
   logic [OFF_W-1:0]   req_off;
   logic [EXT_W-1:0]   wb_line_addr, fill_line_addr, ld_addr;
   logic [OFF_W-1:0]   idx_prev;
   logic               cnt_last, set_last, lookup_hit, out_free, accept;
   logic               fin, rsp_load;
   result_type         fin_res;

   assign req_addr_ext = EXT_W'(req_ch.byte_address);
   assign req_tag      = req_addr_ext[EXT_W-1:OFF_W+SET_W];
   assign req_set      = req_addr_ext[OFF_W+SET_W-1:OFF_W];
   assign req_off      = req_addr_ext[OFF_W-1:0];

   assign idx_prev       = cnt_ff[OFF_W-1:0] - OFF_W'(1);
   assign wb_line_addr   = {vic_tag_ff, cur_set_ff, idx_prev};
   assign fill_line_addr = {tag_ff, cur_set_ff, cnt_ff[OFF_W-1:0]};
   assign ld_addr        = {tag_ff, cur_set_ff, off_ff};
   assign cnt_last       = (cnt_ff == (OFF_W+1)'(LINE_BYTES));
   assign set_last       = (cur_set_ff == SET_W'(NUM_SETS-1));
   assign lookup_hit     = valid_ff[cur_set_ff] && (tag_rdata == tag_ff);
   assign out_free       = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.read_byte           = rsp_res_ff.read_byte;
   assign rsp_ch.hit                 = rsp_res_ff.hit;
   assign rsp_ch.victim_written_back = rsp_res_ff.victim_written_back;

   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      valid_in    = valid_ff;
      dirty_in    = dirty_ff;
      func_in     = func_ff;
      tag_in      = tag_ff;
      vic_tag_in  = vic_tag_ff;
      cur_set_in  = cur_set_ff;
      off_in      = off_ff;
      wbyte_in    = wbyte_ff;
      cnt_in      = cnt_ff;
      wb_flag_in  = wb_flag_ff;
      cap_rd_in   = cap_rd_ff;
      hold_res_in = hold_res_ff;
      rsp_res_in  = rsp_res_ff;
      tag_we      = 1'b0;
      tag_waddr   = cur_set_ff;
      tag_wdata   = tag_ff;
      tag_raddr   = cur_set_ff;
      line_we     = 1'b0;
      line_waddr  = {cur_set_ff, off_ff};
      line_wdata  = wbyte_ff;
      line_raddr  = {cur_set_ff, cnt_ff[OFF_W-1:0]};
      mem_we      = 1'b0;
      mem_waddr   = wb_line_addr[MEM_AW-1:0];
      mem_wdata   = line_rdata;
      mem_raddr   = fill_line_addr[MEM_AW-1:0];
      fin         = 1'b0;
      fin_res     = '0;
      rsp_load    = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + MEM_AW'(1);
            if (clr_cnt_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // rams look up the incoming address while the request transfers
            tag_raddr  = req_set;
            line_raddr = {req_set, req_off};
            mem_raddr  = req_addr_ext[MEM_AW-1:0];
            if (accept) begin
               func_in    = req_ch.func;
               tag_in     = req_tag;
               cur_set_in = req_set;
               off_in     = req_off;
               wbyte_in   = req_ch.write_byte;
               state_in   = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            case (func_ff)
               FUNC_READ, FUNC_WRITE: begin
                  if (lookup_hit) begin
                     fin         = 1'b1;
                     fin_res.hit = 1'b1;
                     if (func_ff == FUNC_READ) begin
                        fin_res.read_byte = line_rdata;
                     end else begin
                        line_we              = 1'b1;
                        dirty_in[cur_set_ff] = 1'b1;
                     end
                  end else begin
                     cnt_in = '0;
                     if (valid_ff[cur_set_ff] && dirty_ff[cur_set_ff]) begin
                        vic_tag_in = tag_rdata;
                        wb_flag_in = 1'b1;
                        state_in   = ST_WB;
                     end else begin
                        wb_flag_in = 1'b0;
                        state_in   = ST_FILL;
                     end
                  end
               end
               FUNC_FLUSH: begin
                  cur_set_in = '0;
                  state_in   = ST_FL_TAG;
               end
               FUNC_LOAD: begin
                  mem_we    = 1'b1;
                  mem_waddr = ld_addr[MEM_AW-1:0];
                  mem_wdata = wbyte_ff;
                  fin       = 1'b1;
               end
               FUNC_PEEK: begin
                  fin               = 1'b1;
                  fin_res.read_byte = mem_rdata;
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end
         ST_FL_TAG: begin
            state_in = ST_FL_CHK;
         end
         ST_FL_CHK: begin
            // invalid lines are skipped
            if (valid_ff[cur_set_ff]) begin
               vic_tag_in = tag_rdata;
               cnt_in     = '0;
               state_in   = ST_WB;
            end else if (set_last) begin
               fin = 1'b1;
            end else begin
               cur_set_in = cur_set_ff + SET_W'(1);
               state_in   = ST_FL_TAG;
            end
         end
         ST_WB: begin
            // read byte n of the line, write byte n-1 to memory
            if (cnt_ff != '0) begin
               mem_we = 1'b1;
            end
            cnt_in = cnt_ff + (OFF_W+1)'(1);
            if (cnt_last) begin
               cnt_in = '0;
               if (func_ff == FUNC_FLUSH) begin
                  if (set_last) begin
                     fin = 1'b1;
                  end else begin
                     cur_set_in = cur_set_ff + SET_W'(1);
                     state_in   = ST_FL_TAG;
                  end
               end else begin
                  state_in = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            if (cnt_ff != '0) begin
               line_we    = 1'b1;
               line_waddr = {cur_set_ff, idx_prev};
               // a write miss merges its byte on the way in
               if (func_ff == FUNC_WRITE && idx_prev == off_ff) begin
                  line_wdata = wbyte_ff;
               end else begin
                  line_wdata = mem_rdata;
               end
               if (idx_prev == off_ff) begin
                  cap_rd_in = mem_rdata;
               end
            end
            cnt_in = cnt_ff + (OFF_W+1)'(1);
            if (cnt_last) begin
               tag_we               = 1'b1;
               valid_in[cur_set_ff] = 1'b1;
               dirty_in[cur_set_ff] = (func_ff == FUNC_WRITE);
               fin                  = 1'b1;
               fin_res.victim_written_back = wb_flag_ff;
               if (func_ff == FUNC_READ) begin
                  fin_res.read_byte = (idx_prev == off_ff) ? mem_rdata : cap_rd_ff;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_load   = 1'b1;
               rsp_res_in = hold_res_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // park the result when the response register is still occupied
      if (fin) begin
         if (out_free) begin
            rsp_load   = 1'b1;
            rsp_res_in = fin_res;
            state_in   = ST_IDLE;
         end else begin
            hold_res_in = fin_res;
            state_in    = ST_HOLD;
         end
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      tag_ff      <= tag_in;
      vic_tag_ff  <= vic_tag_in;
      cur_set_ff  <= cur_set_in;
      off_ff      <= off_in;
      wbyte_ff    <= wbyte_in;
      cnt_ff      <= cnt_in;
      wb_flag_ff  <= wb_flag_in;
      cap_rd_ff   <= cap_rd_in;
      hold_res_ff <= hold_res_in;
      rsp_res_ff  <= rsp_res_in;
   end

   dmwbc_ram #(.WIDTH(TAG_W), .DEPTH(NUM_SETS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (tag_waddr),
      .wr_data (tag_wdata),
      .rd_addr (tag_raddr),
      .rd_data (tag_rdata)
   );

   dmwbc_ram #(.WIDTH(BYTE_W), .DEPTH(NUM_SETS * LINE_BYTES)) u_line_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (line_waddr),
      .wr_data (line_wdata),
      .rd_addr (line_raddr),
      .rd_data (line_rdata)
   );

   dmwbc_ram #(.WIDTH(BYTE_W), .DEPTH(MEM_BYTES)) u_mem_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule

FILE: rtl/dmwbc_checker.sv
// dmwbc_checker: port-level assertions for the cache, bound to the top level
// depends on dmwbc_pkg and direct_mapped_write_back_cache
module dmwbc_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [dmwbc_pkg::BYTE_W-1:0] rsp_read_byte,
   input logic                     rsp_hit,
   input logic                     rsp_victim_written_back
);
   import dmwbc_pkg::*;

   logic [1:0] pend_ff, pend_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // requests taken but not yet answered
   always_comb begin
      pend_in = pend_ff;
      if (req_xfer && !rsp_xfer) begin
         pend_in = pend_ff + 2'd1;
      end else if (rsp_xfer && !req_xfer) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_byte)
         && $stable(rsp_hit) && $stable(rsp_victim_written_back))
      else $error("response dropped or changed while stalled");

   a_hit_no_wb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_victim_written_back))
      else $error("write-back reported on a hit");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without an outstanding request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> pend_ff == 2'd0 || (pend_ff == 2'd1 && rsp_valid))
      else $error("request taken while another one is still in progress");

endmodule

bind direct_mapped_write_back_cache dmwbc_checker u_dmwbc_checker (
   .clock                   (clock),
   .reset                   (reset),
   .req_valid               (req_ch.valid),
   .req_ready               (req_ch.ready),
   .rsp_valid               (rsp_ch.valid),
   .rsp_ready               (rsp_ch.ready),
   .rsp_read_byte           (rsp_ch.read_byte),
   .rsp_hit                 (rsp_ch.hit),
   .rsp_victim_written_back (rsp_ch.victim_written_back)
);

FILE: tb/direct_mapped_write_back_cache_tb.sv
`timescale 1ns / 100ps
// direct_mapped_write_back_cache_tb: self-checking bench for the write-back cache, with a
// burst driver, a stalling receiver and an in-order response checker built on a cache model
// depends on dmwbc_pkg, dmwbc_req_if, dmwbc_rsp_if and direct_mapped_write_back_cache
module direct_mapped_write_back_cache_tb;
   import dmwbc_pkg::*;

   localparam int NUM_SETS    = 8;
   localparam int LINE_BYTES  = 8;
   localparam int MEM_BYTES   = 1024;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT  = 120;
   localparam int LONG_HOLD   = 300;
   localparam int HOLD_AFTER  = 400;

   localparam func_type FUNC_UNUSED_FIRST = 3'd5;
   localparam func_type FUNC_UNUSED_LAST  = 3'd7;

   typedef struct {
      func_type          func;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
      bit                drain_first;
   } cache_op_type;

   logic clock;
   logic reset;

   dmwbc_req_if req_ch ();
   dmwbc_rsp_if rsp_ch ();

   direct_mapped_write_back_cache #(
      .NUM_SETS  (NUM_SETS),
      .LINE_BYTES(LINE_BYTES),
      .MEM_BYTES (MEM_BYTES)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // cache model state
   bit                line_ok    [NUM_SETS];
   bit                line_dirty [NUM_SETS];
   logic [3:0]        line_tag   [NUM_SETS];
   logic [BYTE_W-1:0] line_data  [NUM_SETS*LINE_BYTES];
   logic [BYTE_W-1:0] mem_image  [MEM_BYTES];

   cache_op_type op_queue [$];
   result_type   awaited  [$];

   int in_flight;
   int results_done;
   int mismatches;
   int cycle_count;

   int  gap_left;
   int  burst_left;
   bit  offer;
   cache_op_type op;

   int  hold_left;
   bit  long_hold_done;
   int  mode;
   int  mode_left;
   int  mode_phase;
   bit  ready_next;

   result_type got;
   result_type want;
   bit         req_fire;
   bit         rsp_fire;

   task automatic report_mismatch(string what, int got_v, int want_v);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch at result %0d: %s got %0h expected %0h",
                  results_done, what, got_v, want_v);
   endtask

   function automatic void write_back_line(logic [2:0] set);
      logic [ADDR_W-1:0] base;
      base = {line_tag[set], set, 3'd0};
      for (int i = 0; i < LINE_BYTES; i++)
         mem_image[base + i[2:0]] = line_data[{set, i[2:0]}];
   endfunction

   function automatic result_type cache_step(func_type fn, logic [ADDR_W-1:0] addr,
                                             logic [BYTE_W-1:0] wbyte);
      result_type        r;
      logic [2:0]        off;
      logic [2:0]        set;
      logic [3:0]        tag;
      logic [ADDR_W-1:0] base;
      r   = '0;
      off = addr[2:0];
      set = addr[5:3];
      tag = addr[9:6];
      case (fn)
         FUNC_READ, FUNC_WRITE: begin
            if (line_ok[set] && line_tag[set] == tag) begin
               r.hit = 1'b1;
            end else begin
               if (line_ok[set] && line_dirty[set]) begin
                  write_back_line(set);
                  r.victim_written_back = 1'b1;
               end
               base = {tag, set, 3'd0};
               for (int i = 0; i < LINE_BYTES; i++)
                  line_data[{set, i[2:0]}] = mem_image[base + i[2:0]];
               line_tag[set]   = tag;
               line_ok[set]    = 1'b1;
               line_dirty[set] = 1'b0;
            end
            if (fn == FUNC_READ) begin
               r.read_byte = line_data[{set, off}];
            end else begin
               line_data[{set, off}] = wbyte;
               line_dirty[set]       = 1'b1;
            end
         end
         FUNC_FLUSH: begin
            // invalid lines are skipped, valid and dirty bits stay as they are
            for (int s = 0; s < NUM_SETS; s++)
               if (line_ok[s]) write_back_line(s[2:0]);
         end
         FUNC_LOAD: mem_image[addr] = wbyte;
         FUNC_PEEK: r.read_byte = mem_image[addr];
         default: ;
      endcase
      return r;
   endfunction

   task automatic push_op(func_type fn, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data,
                          bit drain_first);
      cache_op_type o;
      o.func        = fn;
      o.addr        = addr;
      o.data        = data;
      o.drain_first = drain_first;
      op_queue = {op_queue, o};
   endtask

   task automatic add_random_phase(int count);
      logic [3:0]        hot [3];
      logic [ADDR_W-1:0] a;
      func_type          fn;
      int                pick;
      bit                first;
      for (int k = 0; k < 3; k++) hot[k] = 4'($urandom_range(0, 15));
      first = 1'b1;
      // loader pattern: fill a line straight into memory, then read it through the cache
      if ($urandom_range(0, 2) == 0) begin
         a = {hot[0], 3'($urandom_range(0, 7)), 3'd0};
         for (int k = 0; k < LINE_BYTES; k++) begin
            push_op(FUNC_LOAD, a + k[2:0], 8'($urandom_range(0, 255)), first);
            first = 1'b0;
         end
         for (int k = 0; k < LINE_BYTES; k++)
            push_op(FUNC_READ, a + k[2:0], 8'($urandom_range(0, 255)), 1'b0);
      end
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0)
            a = 10'($urandom_range(0, MEM_BYTES - 1));
         else
            a = {hot[$urandom_range(0, 2)], 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))};
         pick = $urandom_range(0, 99);
         if (pick < 40)      fn = FUNC_READ;
         else if (pick < 75) fn = FUNC_WRITE;
         else if (pick < 85) fn = FUNC_LOAD;
         else if (pick < 94) fn = FUNC_PEEK;
         else if (pick < 97) fn = FUNC_FLUSH;
         else                fn = func_type'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));
         push_op(fn, a, 8'($urandom_range(0, 255)), first);
         first = 1'b0;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.func         = FUNC_READ;
      req_ch.byte_address = '0;
      req_ch.write_byte   = '0;
      rsp_ch.ready        = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left   = 0;
         burst_left = 1;
      end else if (!req_ch.valid || req_ch.ready) begin
         offer = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (op_queue.size() > 0 &&
                      (!op_queue[0].drain_first || (in_flight == 0 && !req_ch.valid))) begin
            op    = op_queue.pop_front();
            offer = 1'b1;
            req_ch.func         <= op.func;
            req_ch.byte_address <= op.addr;
            req_ch.write_byte   <= op.data;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 32);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
         req_ch.valid <= offer;
      end
   end

   // receiver: stall pattern switches between randomly chosen modes, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left      = 0;
         long_hold_done = 1'b0;
         mode_left      = 0;
         mode           = 0;
         mode_phase     = 0;
      end else begin
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (!long_hold_done && results_done >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
            ready_next     = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 4);
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            mode_phase++;
            case (mode)
               0:       ready_next = 1'b1;
               1:       ready_next = ($urandom_range(0, 1) == 1);
               2:       ready_next = ($urandom_range(0, 7) != 0);
               3:       ready_next = (mode_phase % 4 != 0);
               default: ready_next = ($urandom_range(0, 4) == 0);
            endcase
         end
         rsp_ch.ready <= ready_next;
      end
   end

   // monitor: predict on each request transfer, check each response transfer in order
   always @(posedge clock) begin
      if (reset) begin
         in_flight    <= 0;
         results_done <= 0;
      end else begin
         req_fire = req_ch.valid && req_ch.ready;
         rsp_fire = rsp_ch.valid && rsp_ch.ready;
         if (rsp_fire) begin
            got.read_byte           = rsp_ch.read_byte;
            got.hit                 = rsp_ch.hit;
            got.victim_written_back = rsp_ch.victim_written_back;
            if (awaited.size() == 0) begin
               report_mismatch("response with nothing pending", int'(got), 0);
            end else begin
               want = awaited.pop_front();
               if (got.read_byte !== want.read_byte)
                  report_mismatch("read_byte", int'(got.read_byte), int'(want.read_byte));
               if (got.hit !== want.hit)
                  report_mismatch("hit", int'(got.hit), int'(want.hit));
               if (got.victim_written_back !== want.victim_written_back)
                  report_mismatch("victim_written_back", int'(got.victim_written_back),
                                  int'(want.victim_written_back));
            end
         end
         if (req_fire)
            awaited = {awaited,
                       cache_step(req_ch.func, req_ch.byte_address, req_ch.write_byte)};
         in_flight    <= in_flight + int'(req_fire) - int'(rsp_fire);
         results_done <= results_done + int'(rsp_fire);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** direct_mapped_write_back_cache: FAILED **");
         $finish;
      end
   end

   initial begin
      mismatches  = 0;
      cycle_count = 0;
      for (int i = 0; i < NUM_SETS; i++) begin
         line_ok[i]    = 1'b0;
         line_dirty[i] = 1'b0;
         line_tag[i]   = '0;
      end
      for (int i = 0; i < NUM_SETS * LINE_BYTES; i++) line_data[i] = '0;
      for (int i = 0; i < MEM_BYTES; i++) mem_image[i] = '0;

      // flush with every line invalid, then cold misses at both address extremes
      push_op(FUNC_FLUSH, 10'h000, 8'h00, 1'b0);
      push_op(FUNC_PEEK,  10'h000, 8'h00, 1'b0);
      push_op(FUNC_READ,  10'h000, 8'hFF, 1'b0);
      push_op(FUNC_WRITE, 10'h3FF, 8'hFF, 1'b0);
      push_op(FUNC_READ,  10'h3FF, 8'h00, 1'b0);
      // load bypasses a cached line, so the cache keeps the old byte
      push_op(FUNC_LOAD,  10'h3FF, 8'hA5, 1'b0);
      push_op(FUNC_READ,  10'h3FF, 8'h00, 1'b0);
      push_op(FUNC_PEEK,  10'h3FF, 8'h00, 1'b0);
      // flush writes the dirty line over the loaded byte
      push_op(FUNC_FLUSH, 10'h155, 8'hFF, 1'b0);
      push_op(FUNC_PEEK,  10'h3FF, 8'h00, 1'b0);
      push_op(FUNC_LOAD,  10'h000, 8'h5A, 1'b0);
      push_op(FUNC_READ,  10'h000, 8'h00, 1'b0);
      push_op(FUNC_WRITE, 10'h000, 8'h11, 1'b0);
      // conflict miss on a dirty victim, then on a clean one
      push_op(FUNC_READ,  10'h040, 8'h00, 1'b0);
      push_op(FUNC_PEEK,  10'h000, 8'h00, 1'b0);
      push_op(FUNC_LOAD,  10'h3C7, 8'h80, 1'b0);
      push_op(FUNC_READ,  10'h3C7, 8'h00, 1'b0);
      push_op(FUNC_WRITE, 10'h07F, 8'h00, 1'b0);
      push_op(FUNC_UNUSED_FIRST,         10'h2AA, 8'h55, 1'b0);
      push_op(FUNC_UNUSED_FIRST + 3'd1,  10'h155, 8'hAA, 1'b0);
      push_op(FUNC_UNUSED_LAST,          10'h3FF, 8'hFF, 1'b0);
      push_op(FUNC_READ,  10'h2AA, 8'h00, 1'b0);
      push_op(FUNC_WRITE, 10'h155, 8'h55, 1'b0);
      push_op(FUNC_FLUSH, 10'h000, 8'h00, 1'b0);
      push_op(FUNC_PEEK,  10'h155, 8'h00, 1'b0);

      for (int p = 0; p < 10; p++) add_random_phase(150);

      while (op_queue.size() != 0 || req_ch.valid) @(negedge clock);
      while (awaited.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      if (awaited.size() != 0)
         report_mismatch("responses still pending", awaited.size(), 0);

      if (mismatches == 0)
         $display("** direct_mapped_write_back_cache: PASSED **");
      else
         $display("** direct_mapped_write_back_cache: FAILED **");
      $finish;
   end

endmodule

FILE: sim.f
rtl/dmwbc_pkg.sv
rtl/dmwbc_req_if.sv
rtl/dmwbc_rsp_if.sv
rtl/dmwbc_ram.sv
rtl/direct_mapped_write_back_cache.sv
rtl/dmwbc_checker.sv
tb/direct_mapped_write_back_cache_tb.sv
